@@ hdl/mcrg_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcrg_pkg
// Shared constants, point map tables and control types of the ramp generator.
// ----------------------------------------------------------------------------
package mcrg_pkg;

    localparam int POINT_COUNT = 16;
    localparam int IDX_W       = $clog2(POINT_COUNT);
    localparam int LEVEL_W     = 16;
    localparam int POINT_W     = 8;
    localparam int SLICE_W     = 3;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(POINT_COUNT - 1);

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_SET   = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef enum logic {
        KIND_UPDATE = 1'b0,
        KIND_REPLY  = 1'b1
    } t_kind;

    localparam logic [POINT_COUNT-1:0] POINT_VALID = 16'hFEFE;

    localparam logic [SLICE_W-1:0] POINT_SLICE [POINT_COUNT] = '{
        3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd2, 3'd2, 3'd3,
        3'd0, 3'd4, 3'd4, 3'd5, 3'd5, 3'd6, 3'd6, 3'd7
    };

    localparam logic POINT_CHANNEL [POINT_COUNT] = '{
        1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0,
        1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0
    };

    typedef struct packed {
        logic accept;
        logic scan_en;
        logic flush_en;
        logic reply_en;
    } t_ctl;

    typedef struct packed {
        logic out_free;
        logic pend_valid;
        logic idx_last;
    } t_sts;

endpackage
`default_nettype wire

@@ hdl/mcrg_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcrg_ctrl
// Command sequencer: accepts a word, runs the tick scan, flushes the held
// update and issues query replies.
// ----------------------------------------------------------------------------
module mcrg_ctrl
    import mcrg_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [1:0] i_cmd,
    input  wire t_sts       i_sts,
    output t_ctl            o_ctl,
    output logic            o_stall
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_FLUSH = 4'b0100,
        ST_REPLY = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state        = r_state;
        o_ctl          = '0;
        o_stall        = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_stall      = 1'b0;
                o_ctl.accept = i_valid;
                if (i_valid) begin
                    unique case (t_cmd'(i_cmd))
                        CMD_TICK: n_state = ST_SCAN;
                        CMD_READ: n_state = ST_REPLY;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN: begin
                o_ctl.scan_en = i_sts.out_free;
                if (i_sts.out_free && i_sts.idx_last) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!i_sts.pend_valid) begin
                    n_state = ST_IDLE;
                end else if (i_sts.out_free) begin
                    o_ctl.flush_en = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_REPLY: begin
                o_ctl.reply_en = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

@@ hdl/mcrg_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcrg_datapath
// Point stores, step arithmetic, held update and output register.
// ----------------------------------------------------------------------------
module mcrg_datapath
    import mcrg_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_ctl               i_ctl,
    output t_sts                    o_sts,
    input  wire logic [1:0]         i_cmd,
    input  wire logic [POINT_W-1:0] i_point,
    input  wire logic [LEVEL_W-1:0] i_target,
    input  wire logic [LEVEL_W-1:0] i_step,
    input  wire logic               i_stall,
    output logic                    o_valid,
    output logic                    o_kind,
    output logic [IDX_W-1:0]        o_point_id,
    output logic [SLICE_W-1:0]      o_slice,
    output logic                    o_channel,
    output logic [LEVEL_W-1:0]      o_level,
    output logic [LEVEL_W-1:0]      o_step_out,
    output logic [LEVEL_W-1:0]      o_target_out,
    output logic                    o_point_ok,
    output logic                    o_last
);

    logic [LEVEL_W-1:0] r_level  [POINT_COUNT];
    logic [LEVEL_W-1:0] r_step   [POINT_COUNT];
    logic [LEVEL_W-1:0] r_target [POINT_COUNT];

    logic [IDX_W-1:0]   r_idx;
    logic [POINT_W-1:0] r_qpt;

    logic               r_pend_v;
    logic [IDX_W-1:0]   r_pend_id;
    logic [LEVEL_W-1:0] r_pend_lvl;

    logic               r_ov;
    logic               r_kind;
    logic [IDX_W-1:0]   r_id;
    logic [SLICE_W-1:0] r_slice;
    logic               r_chan;
    logic [LEVEL_W-1:0] r_lvl;
    logic [LEVEL_W-1:0] r_stp;
    logic [LEVEL_W-1:0] r_tgt;
    logic               r_ok;
    logic               r_last;

    logic [IDX_W-1:0]   addr;
    logic [LEVEL_W-1:0] cur_lvl;
    logic [LEVEL_W-1:0] cur_stp;
    logic [LEVEL_W-1:0] cur_tgt;
    logic [LEVEL_W-1:0] diff;
    logic [LEVEL_W-1:0] new_lvl;
    logic               hit;
    logic               out_free;
    logic               out_load;
    logic               q_ok;
    logic               set_ok;

    assign out_free = !r_ov || !i_stall;
    assign addr     = i_ctl.reply_en ? r_qpt[IDX_W-1:0] : r_idx;
    assign cur_lvl  = r_level[addr];
    assign cur_stp  = r_step[addr];
    assign cur_tgt  = r_target[addr];
    assign q_ok     = (r_qpt[POINT_W-1:IDX_W] == '0) && POINT_VALID[r_qpt[IDX_W-1:0]];
    assign set_ok   = (i_point[POINT_W-1:IDX_W] == '0) && POINT_VALID[i_point[IDX_W-1:0]];

    always_comb begin
        hit = POINT_VALID[r_idx] && (cur_stp != '0) && (cur_lvl != cur_tgt);
        if (cur_lvl < cur_tgt) begin
            diff    = cur_tgt - cur_lvl;
            new_lvl = (diff < cur_stp) ? cur_tgt : cur_lvl + cur_stp;
        end else begin
            diff    = cur_lvl - cur_tgt;
            new_lvl = (diff < cur_stp) ? cur_tgt : cur_lvl - cur_stp;
        end
    end

    assign out_load = (i_ctl.scan_en && hit && r_pend_v) || i_ctl.flush_en
                      || i_ctl.reply_en;

    assign o_sts.out_free   = out_free;
    assign o_sts.pend_valid = r_pend_v;
    assign o_sts.idx_last   = (r_idx == IDX_LAST);

    // point stores
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_ctl.accept && t_cmd'(i_cmd) == CMD_CLEAR)) begin
            for (int i = 0; i < POINT_COUNT; i++) begin
                r_level[i]  <= '0;
                r_step[i]   <= '0;
                r_target[i] <= '0;
            end
        end else begin
            if (i_ctl.accept && t_cmd'(i_cmd) == CMD_SET && set_ok) begin
                r_step[i_point[IDX_W-1:0]]   <= i_step;
                r_target[i_point[IDX_W-1:0]] <= i_target;
            end
            if (i_ctl.scan_en && hit) begin
                r_level[r_idx] <= new_lvl;
            end
        end
    end

    // scan position and held update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_pend_v <= 1'b0;
        end else begin
            if (i_ctl.scan_en) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_ctl.scan_en && hit) begin
                r_pend_v <= 1'b1;
            end else if (i_ctl.flush_en) begin
                r_pend_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_qpt <= i_point;
        end
        if (i_ctl.scan_en && hit) begin
            r_pend_id  <= r_idx;
            r_pend_lvl <= new_lvl;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load) begin
            r_ov <= 1'b1;
        end else if (!i_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            if (i_ctl.reply_en) begin
                r_kind  <= KIND_REPLY;
                r_id    <= r_qpt[IDX_W-1:0];
                r_ok    <= q_ok;
                r_last  <= 1'b1;
                r_slice <= q_ok ? POINT_SLICE[r_qpt[IDX_W-1:0]] : '0;
                r_chan  <= q_ok ? POINT_CHANNEL[r_qpt[IDX_W-1:0]] : 1'b0;
                r_lvl   <= q_ok ? cur_lvl : '0;
                r_stp   <= q_ok ? cur_stp : '0;
                r_tgt   <= q_ok ? cur_tgt : '0;
            end else begin
                r_kind  <= KIND_UPDATE;
                r_id    <= r_pend_id;
                r_ok    <= 1'b1;
                r_last  <= i_ctl.flush_en;
                r_slice <= POINT_SLICE[r_pend_id];
                r_chan  <= POINT_CHANNEL[r_pend_id];
                r_lvl   <= r_pend_lvl;
                r_stp   <= '0;
                r_tgt   <= '0;
            end
        end
    end

    assign o_valid      = r_ov;
    assign o_kind       = r_kind;
    assign o_point_id   = r_id;
    assign o_slice      = r_slice;
    assign o_channel    = r_chan;
    assign o_level      = r_lvl;
    assign o_step_out   = r_stp;
    assign o_target_out = r_tgt;
    assign o_point_ok   = r_ok;
    assign o_last       = r_last;

endmodule
`default_nettype wire

@@ hdl/multi_channel_ramp_generator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_channel_ramp_generator
// Sixteen-point slew-rate-limited ramp generator for PWM levels.
//
// Input channel (i_valid / o_stall) carries one command word: tick, set,
// clear or query. A word is taken only when the block is idle.
// Set and clear finish in the cycle they are taken and give no output.
// A query gives one reply word through the output register once it is free.
// A tick scans the points one per cycle while the output register is free,
// then flushes any held update before the next word is taken. Each moved point
// gives an update word; one update is held back so the final one of the
// scan carries o_last.
// Output channel (o_valid / i_stall) comes from an output register. While
// the receiver stalls, the word holds and the scan or reply waits.
// Reset clears all levels, steps and targets to zero and empties the
// output register.
// ----------------------------------------------------------------------------
module multi_channel_ramp_generator
    import mcrg_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [1:0]         i_cmd,
    input  wire logic [POINT_W-1:0] i_point,
    input  wire logic [LEVEL_W-1:0] i_target,
    input  wire logic [LEVEL_W-1:0] i_step,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic                    o_kind,
    output logic [IDX_W-1:0]        o_point_id,
    output logic [SLICE_W-1:0]      o_slice,
    output logic                    o_channel,
    output logic [LEVEL_W-1:0]      o_level,
    output logic [LEVEL_W-1:0]      o_step_out,
    output logic [LEVEL_W-1:0]      o_target_out,
    output logic                    o_point_ok,
    output logic                    o_last
);

    t_ctl ctl;
    t_sts sts;

    mcrg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_cmd   (i_cmd),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .o_stall (o_stall)
    );

    mcrg_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .o_sts        (sts),
        .i_cmd        (i_cmd),
        .i_point      (i_point),
        .i_target     (i_target),
        .i_step       (i_step),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_kind       (o_kind),
        .o_point_id   (o_point_id),
        .o_slice      (o_slice),
        .o_channel    (o_channel),
        .o_level      (o_level),
        .o_step_out   (o_step_out),
        .o_target_out (o_target_out),
        .o_point_ok   (o_point_ok),
        .o_last       (o_last)
    );

endmodule
`default_nettype wire

@@ hdl/mcrg_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcrg_checker
// Port-level checks on the output words of the ramp generator.
// ----------------------------------------------------------------------------
module mcrg_checker
    import mcrg_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_stall,
    input wire logic               o_valid,
    input wire logic               o_kind,
    input wire logic [IDX_W-1:0]   o_point_id,
    input wire logic [SLICE_W-1:0] o_slice,
    input wire logic               o_channel,
    input wire logic [LEVEL_W-1:0] o_level,
    input wire logic [LEVEL_W-1:0] o_step_out,
    input wire logic [LEVEL_W-1:0] o_target_out,
    input wire logic               o_point_ok,
    input wire logic               o_last
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_level) && $stable(o_point_id)
            && $stable(o_last))
        else $error("stalled output word changed");

    a_update_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_UPDATE |-> o_point_ok && o_step_out == '0
            && o_target_out == '0 && o_point_id != 4'd0 && o_point_id != 4'd8)
        else $error("malformed level update");

    a_reply_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_REPLY |-> o_last)
        else $error("query reply without last");

    a_missing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_point_ok |-> o_level == '0 && o_slice == '0 && !o_channel
            && o_step_out == '0 && o_target_out == '0)
        else $error("missing point reply not zeroed");

endmodule

bind multi_channel_ramp_generator mcrg_checker u_mcrg_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_stall      (i_stall),
    .o_valid      (o_valid),
    .o_kind       (o_kind),
    .o_point_id   (o_point_id),
    .o_slice      (o_slice),
    .o_channel    (o_channel),
    .o_level      (o_level),
    .o_step_out   (o_step_out),
    .o_target_out (o_target_out),
    .o_point_ok   (o_point_ok),
    .o_last       (o_last)
);
`default_nettype wire

@@ bench/multi_channel_ramp_generator_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_channel_ramp_generator_checker
// Watches the command and result channels of the ramp generator. It keeps
// its own copy of the level, step and target stores, works out the words
// that each taken command must produce, and compares every result word
// field by field with the oldest word still owed.
// ----------------------------------------------------------------------------
module multi_channel_ramp_generator_checker
    import mcrg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [1:0]         i_cmd,
    input  logic [POINT_W-1:0] i_point,
    input  logic [LEVEL_W-1:0] i_target,
    input  logic [LEVEL_W-1:0] i_step,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic               i_kind,
    input  logic [IDX_W-1:0]   i_point_id,
    input  logic [SLICE_W-1:0] i_slice,
    input  logic               i_channel,
    input  logic [LEVEL_W-1:0] i_level,
    input  logic [LEVEL_W-1:0] i_step_out,
    input  logic [LEVEL_W-1:0] i_target_out,
    input  logic               i_point_ok,
    input  logic               i_last,
    output int                 o_errors,
    output int                 o_pending
);

    typedef struct {
        t_kind               kind;
        logic [IDX_W-1:0]    point_id;
        logic [SLICE_W-1:0]  slice;
        logic                channel;
        logic [LEVEL_W-1:0]  level;
        logic [LEVEL_W-1:0]  step_out;
        logic [LEVEL_W-1:0]  target_out;
        logic                point_ok;
        logic                last;
    } t_ramp_word;

    logic [LEVEL_W-1:0] level_mem  [POINT_COUNT];
    logic [LEVEL_W-1:0] step_mem   [POINT_COUNT];
    logic [LEVEL_W-1:0] target_mem [POINT_COUNT];
    t_ramp_word         owed_words [$];

    initial o_errors = 0;

    function automatic t_ramp_word make_word(t_kind k, logic [IDX_W-1:0] id, logic ok,
                                             logic [LEVEL_W-1:0] lvl,
                                             logic [LEVEL_W-1:0] stp,
                                             logic [LEVEL_W-1:0] tgt);
        t_ramp_word w;
        w.kind       = k;
        w.point_id   = id;
        w.slice      = ok ? POINT_SLICE[id] : '0;
        w.channel    = ok ? POINT_CHANNEL[id] : 1'b0;
        w.level      = lvl;
        w.step_out   = stp;
        w.target_out = tgt;
        w.point_ok   = ok;
        w.last       = 1'b0;
        return w;
    endfunction

    task automatic clear_points();
        for (int i = 0; i < POINT_COUNT; i++) begin
            level_mem[i]  = '0;
            step_mem[i]   = '0;
            target_mem[i] = '0;
        end
    endtask

    task automatic apply_command(t_cmd cmd, logic [POINT_W-1:0] pt,
                                 logic [LEVEL_W-1:0] tgt, logic [LEVEL_W-1:0] stp);
        logic [LEVEL_W-1:0] cur;
        logic [LEVEL_W-1:0] nxt;
        t_ramp_word         w;
        int                 moved;
        logic               known;
        moved = 0;
        known = (pt < POINT_COUNT) && POINT_VALID[pt[IDX_W-1:0]];
        case (cmd)
            CMD_TICK: begin
                for (int i = 0; i < POINT_COUNT; i++) begin
                    cur = level_mem[i];
                    if (POINT_VALID[i] && step_mem[i] != 0 && cur != target_mem[i]) begin
                        if (cur < target_mem[i]) begin
                            nxt = (target_mem[i] - cur < step_mem[i]) ? target_mem[i]
                                                                      : cur + step_mem[i];
                        end else begin
                            nxt = (cur - target_mem[i] < step_mem[i]) ? target_mem[i]
                                                                      : cur - step_mem[i];
                        end
                        level_mem[i] = nxt;
                        owed_words.push_back(make_word(KIND_UPDATE, IDX_W'(i), 1'b1,
                                                       nxt, '0, '0));
                        moved++;
                    end
                end
                if (moved > 0) owed_words[owed_words.size() - 1].last = 1'b1;
            end
            CMD_SET: begin
                if (known) begin
                    target_mem[pt[IDX_W-1:0]] = tgt;
                    step_mem[pt[IDX_W-1:0]]   = stp;
                end
            end
            CMD_CLEAR: clear_points();
            CMD_READ: begin
                if (known) begin
                    w = make_word(KIND_REPLY, pt[IDX_W-1:0], 1'b1, level_mem[pt[IDX_W-1:0]],
                                  step_mem[pt[IDX_W-1:0]], target_mem[pt[IDX_W-1:0]]);
                end else begin
                    w = make_word(KIND_REPLY, pt[IDX_W-1:0], 1'b0, '0, '0, '0);
                end
                w.last = 1'b1;
                owed_words.push_back(w);
            end
        endcase
    endtask

    task automatic check_field(string label, int unsigned want, int unsigned got);
        if (want != got) begin
            o_errors++;
            $display("%0t: %s expected %0h got %0h", $time, label, want, got);
        end
    endtask

    task automatic check_word();
        t_ramp_word want;
        if (owed_words.size() == 0) begin
            o_errors++;
            $display("%0t: word expected none got point %0d level %0h kind %0d",
                     $time, i_point_id, i_level, i_kind);
        end else begin
            want = owed_words.pop_front();
            check_field("kind", want.kind, i_kind);
            check_field("point_id", want.point_id, i_point_id);
            check_field("slice", want.slice, i_slice);
            check_field("channel", want.channel, i_channel);
            check_field("level", want.level, i_level);
            check_field("step_out", want.step_out, i_step_out);
            check_field("target_out", want.target_out, i_target_out);
            check_field("point_ok", want.point_ok, i_point_ok);
            check_field("last", want.last, i_last);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_points();
            owed_words.delete();
            o_pending <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) check_word();
            if (i_in_valid && !i_in_stall) apply_command(t_cmd'(i_cmd), i_point, i_target, i_step);
            o_pending <= owed_words.size();
        end
    end

endmodule

@@ bench/multi_channel_ramp_generator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_channel_ramp_generator_tb
// Drives command words into the ramp generator: a directed run over missing
// points, overshoot, frozen points, clear and queries, then random sets,
// ticks, queries and clears. Both channels idle and stall at random. The
// checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module multi_channel_ramp_generator_tb;
    import mcrg_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_WORDS = 386;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [1:0]         i_cmd;
    logic [POINT_W-1:0] i_point;
    logic [LEVEL_W-1:0] i_target;
    logic [LEVEL_W-1:0] i_step;
    logic               o_valid;
    logic               i_stall;
    logic               o_kind;
    logic [IDX_W-1:0]   o_point_id;
    logic [SLICE_W-1:0] o_slice;
    logic               o_channel;
    logic [LEVEL_W-1:0] o_level;
    logic [LEVEL_W-1:0] o_step_out;
    logic [LEVEL_W-1:0] o_target_out;
    logic               o_point_ok;
    logic               o_last;

    int errors;
    int pending;
    int idle_cycles = 0;
    int send_calm   = 0;
    int recv_calm   = 0;

    always #10 i_clk = ~i_clk;

    multi_channel_ramp_generator dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_cmd        (i_cmd),
        .i_point      (i_point),
        .i_target     (i_target),
        .i_step       (i_step),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_kind       (o_kind),
        .o_point_id   (o_point_id),
        .o_slice      (o_slice),
        .o_channel    (o_channel),
        .o_level      (o_level),
        .o_step_out   (o_step_out),
        .o_target_out (o_target_out),
        .o_point_ok   (o_point_ok),
        .o_last       (o_last)
    );

    multi_channel_ramp_generator_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_cmd        (i_cmd),
        .i_point      (i_point),
        .i_target     (i_target),
        .i_step       (i_step),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_kind       (o_kind),
        .i_point_id   (o_point_id),
        .i_slice      (o_slice),
        .i_channel    (o_channel),
        .i_level      (o_level),
        .i_step_out   (o_step_out),
        .i_target_out (o_target_out),
        .i_point_ok   (o_point_ok),
        .i_last       (o_last),
        .o_errors     (errors),
        .o_pending    (pending)
    );

    // Draw a random wait; now and then hold a stretch with no wait.
    function automatic int pick_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) calm = int'($urandom_range(4, 24));
        return int'($urandom_range(0, 19));
    endfunction

    task automatic send_word(t_cmd cmd, logic [POINT_W-1:0] pt,
                             logic [LEVEL_W-1:0] tgt, logic [LEVEL_W-1:0] stp);
        int gap;
        gap = pick_wait(send_calm);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_cmd    <= cmd;
        i_point  <= pt;
        i_target <= tgt;
        i_step   <= stp;
        i_valid  <= 1'b1;
        do @(posedge i_clk); while (o_stall);
    endtask

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int hold;
        i_stall <= 1'b0;
        forever begin
            hold = pick_wait(recv_calm);
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    initial begin
        int                 r;
        t_cmd               cmd;
        logic [POINT_W-1:0] pt;
        logic [LEVEL_W-1:0] tgt;
        logic [LEVEL_W-1:0] stp;
        i_rst_n  <= 1'b0;
        i_valid  <= 1'b0;
        i_cmd    <= CMD_TICK;
        i_point  <= '0;
        i_target <= '0;
        i_step   <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // missing points, empty tick, ignored sets
        send_word(CMD_READ, 8'd0, 16'h0000, 16'h0000);
        send_word(CMD_READ, 8'd8, 16'h0000, 16'h0000);
        send_word(CMD_READ, 8'd255, 16'hFFFF, 16'hFFFF);
        send_word(CMD_TICK, 8'd0, 16'h0000, 16'h0000);
        send_word(CMD_SET, 8'd0, 16'hFFFF, 16'hFFFF);
        send_word(CMD_SET, 8'd8, 16'hFFFF, 16'hFFFF);
        send_word(CMD_SET, 8'd200, 16'hFFFF, 16'hFFFF);
        // full swing, overshoot, frozen point, unit step
        send_word(CMD_SET, 8'd1, 16'hFFFF, 16'hFFFF);
        send_word(CMD_SET, 8'd2, 16'h000A, 16'h0003);
        send_word(CMD_SET, 8'd15, 16'h1234, 16'h0000);
        send_word(CMD_SET, 8'd9, 16'hFFFF, 16'h0001);
        repeat (4) send_word(CMD_TICK, 8'd0, 16'h0000, 16'h0000);
        send_word(CMD_READ, 8'd1, 16'h0000, 16'h0000);
        send_word(CMD_READ, 8'd15, 16'h0000, 16'h0000);
        send_word(CMD_SET, 8'd1, 16'h0000, 16'hFFFF);
        send_word(CMD_SET, 8'd7, 16'h8000, 16'h7FFF);
        send_word(CMD_TICK, 8'd0, 16'h0000, 16'h0000);
        send_word(CMD_CLEAR, 8'd0, 16'h0000, 16'h0000);
        send_word(CMD_READ, 8'd9, 16'h0000, 16'h0000);
        send_word(CMD_TICK, 8'd0, 16'h0000, 16'h0000);
        send_word(CMD_READ, 8'd24, 16'h0000, 16'h0000);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            r   = int'($urandom_range(0, 99));
            pt  = POINT_W'($urandom);
            tgt = LEVEL_W'($urandom);
            stp = LEVEL_W'($urandom);
            if (r < 40) begin
                cmd = CMD_TICK;
            end else if (r < 70) begin
                cmd = CMD_SET;
                if ($urandom_range(0, 6) != 0) begin
                    pt = POINT_W'($urandom_range(0, POINT_COUNT - 1));
                end
                case ($urandom_range(0, 3))
                    1: stp = LEVEL_W'($urandom_range(1, 255));
                    2: stp = LEVEL_W'($urandom_range(256, 8191));
                    3: stp = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                    default: ;
                endcase
                if ($urandom_range(0, 3) == 0) tgt = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            end else if (r < 97) begin
                cmd = CMD_READ;
                if ($urandom_range(0, 6) != 0) begin
                    pt = POINT_W'($urandom_range(0, POINT_COUNT - 1));
                end
            end else begin
                cmd = CMD_CLEAR;
            end
            send_word(cmd, pt, tgt, stp);
        end
        i_valid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (40) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ multi_channel_ramp_generator.f @@
hdl/mcrg_pkg.sv
hdl/mcrg_ctrl.sv
hdl/mcrg_datapath.sv
hdl/multi_channel_ramp_generator.sv
hdl/mcrg_checker.sv
bench/multi_channel_ramp_generator_checker.sv
bench/multi_channel_ramp_generator_tb.sv
